[design/ccc_pkg.sv]
// Shared types and constants for the cross-monitor copy check unit.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none
package ccc_pkg;

	localparam int MAX_MONITORS = 16;
	localparam int IDX_W        = $clog2(MAX_MONITORS);
	localparam int CNT_W        = 5;
	localparam int COORD_W      = 19;
	localparam int PROBES       = 8;

	localparam logic REG_MONITOR_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] COUNT_RESET = 5'd1;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic             wr;
		logic             start;
		logic             min_en;
		logic             probe_en;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic flag;
	} stat_t;

endpackage
`default_nettype wire

[design/cross_monitor_copy_check_unit.sv]
// Cross-monitor copy check, top level: APB register, controller and datapath.
// A write word is taken while the unit is idle and the next word may follow at once.
// A query with n >= 2 monitors in use runs a minimum pass then a probe pass, one entry
// per cycle, and then shows its result; with n <= 1 it goes straight to the result.
// No new word is taken until the result is issued. A held result word stalls it.
// Reset clears the table to zero, monitor_count to 1 and the output word.
`default_nettype none
module cross_monitor_copy_check_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [2:0]                paddr,
	input  wire logic [31:0]               pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      opcode,
	input  wire logic [ccc_pkg::IDX_W-1:0] entry_index,
	input  wire logic signed [15:0]        entry_left,
	input  wire logic signed [15:0]        entry_top,
	input  wire logic [13:0]               entry_width,
	input  wire logic [13:0]               entry_height,
	input  wire logic signed [15:0]        src_x,
	input  wire logic signed [15:0]        src_y,
	input  wire logic [13:0]               copy_width,
	input  wire logic [13:0]               copy_height,
	input  wire logic signed [15:0]        dst_x,
	input  wire logic signed [15:0]        dst_y,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           decompose
);

	logic [ccc_pkg::CNT_W-1:0] monitor_count_q;
	ccc_pkg::cmd_t             cmd;
	ccc_pkg::stat_t            stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			monitor_count_q <= ccc_pkg::COUNT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == ccc_pkg::REG_MONITOR_COUNT)) begin
			monitor_count_q <= pwdata[ccc_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			ccc_pkg::REG_MONITOR_COUNT: prdata = 32'(monitor_count_q);
			default:                    prdata = '0;
		endcase
	end

	ccc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.monitor_count (monitor_count_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.decompose     (decompose),
		.cmd           (cmd),
		.stat          (stat)
	);

	ccc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.entry_index  (entry_index),
		.entry_left   (entry_left),
		.entry_top    (entry_top),
		.entry_width  (entry_width),
		.entry_height (entry_height),
		.src_x        (src_x),
		.src_y        (src_y),
		.copy_width   (copy_width),
		.copy_height  (copy_height),
		.dst_x        (dst_x),
		.dst_y        (dst_y),
		.stat         (stat)
	);

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (opcode == ccc_pkg::OP_WRITE)) |=> !$rose(out_valid))
		else $error("write word produced a result");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result raised while input side was idle");

	a_single_monitor_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (monitor_count_q <= ccc_pkg::CNT_W'(1))) |-> !decompose)
		else $error("decompose set with a single monitor");

endmodule
`default_nettype wire

[design/ccc_ctrl.sv]
// Sequencer of the cross-monitor copy check: minimum pass, probe pass, result word.
// Depends on ccc_pkg; drives ccc_dpath through cmd_t and reads stat_t back.
`default_nettype none
module ccc_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       opcode,
	input  wire logic [ccc_pkg::CNT_W-1:0]  monitor_count,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            decompose,
	output ccc_pkg::cmd_t                   cmd,
	input  wire ccc_pkg::stat_t             stat
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MIN    = 4'b0010,
		ST_PROBE  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [ccc_pkg::IDX_W-1:0]   idx_q;
	logic                        out_valid_q;
	logic                        decompose_q;
	logic [ccc_pkg::CNT_W-1:0]   used;
	logic [ccc_pkg::IDX_W-1:0]   last_idx;
	logic                        at_last;
	logic                        accept;
	logic                        slot_free;

	assign used = (monitor_count > ccc_pkg::CNT_W'(ccc_pkg::MAX_MONITORS)) ?
		ccc_pkg::CNT_W'(ccc_pkg::MAX_MONITORS) : monitor_count;
	assign last_idx  = ccc_pkg::IDX_W'(used - ccc_pkg::CNT_W'(1));
	assign at_last   = (idx_q == last_idx);
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign decompose = decompose_q;

	always_comb begin
		cmd.wr       = accept && (opcode == ccc_pkg::OP_WRITE);
		cmd.start    = accept && (opcode == ccc_pkg::OP_QUERY);
		cmd.min_en   = (state_q == ST_MIN);
		cmd.probe_en = (state_q == ST_PROBE);
		cmd.idx      = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			decompose_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (cmd.start) begin
						state_q <= (used > ccc_pkg::CNT_W'(1)) ? ST_MIN : ST_FINISH;
					end
				end
				ST_MIN: begin
					if (at_last) begin
						idx_q   <= '0;
						state_q <= ST_PROBE;
					end else begin
						idx_q <= idx_q + ccc_pkg::IDX_W'(1);
					end
				end
				ST_PROBE: begin
					if (at_last) begin
						idx_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + ccc_pkg::IDX_W'(1);
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						decompose_q <= stat.flag;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[design/ccc_dpath.sv]
// Datapath of the cross-monitor copy check: monitor table, minimum offsets,
// eight corner probes and their first-hit monitors. Depends on ccc_pkg.
`default_nettype none
module ccc_dpath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ccc_pkg::cmd_t             cmd,
	input  wire logic [ccc_pkg::IDX_W-1:0] entry_index,
	input  wire logic signed [15:0]        entry_left,
	input  wire logic signed [15:0]        entry_top,
	input  wire logic [13:0]               entry_width,
	input  wire logic [13:0]               entry_height,
	input  wire logic signed [15:0]        src_x,
	input  wire logic signed [15:0]        src_y,
	input  wire logic [13:0]               copy_width,
	input  wire logic [13:0]               copy_height,
	input  wire logic signed [15:0]        dst_x,
	input  wire logic signed [15:0]        dst_y,
	output ccc_pkg::stat_t                 stat
);

	logic signed [15:0] mon_left_q   [ccc_pkg::MAX_MONITORS];
	logic signed [15:0] mon_top_q    [ccc_pkg::MAX_MONITORS];
	logic [13:0]        mon_width_q  [ccc_pkg::MAX_MONITORS];
	logic [13:0]        mon_height_q [ccc_pkg::MAX_MONITORS];

	logic signed [15:0] min_l_q;
	logic signed [15:0] min_t_q;

	ccc_pkg::coord_t           px_q    [ccc_pkg::PROBES];
	ccc_pkg::coord_t           py_q    [ccc_pkg::PROBES];
	logic                      found_q [ccc_pkg::PROBES];
	logic [ccc_pkg::IDX_W-1:0] hit_q   [ccc_pkg::PROBES];

	logic [13:0]        w1;
	logic [13:0]        h1;
	ccc_pkg::coord_t    sx, sy, dx, dy, sxw, syh, dxw, dyh;
	logic signed [15:0] cur_left, cur_top;
	ccc_pkg::coord_t    l, t, r, b;
	logic               inside_p [ccc_pkg::PROBES];
	logic [ccc_pkg::PROBES-1:0] differs;

	assign w1  = (copy_width  == 14'd0) ? 14'd0 : copy_width  - 14'd1;
	assign h1  = (copy_height == 14'd0) ? 14'd0 : copy_height - 14'd1;
	assign sx  = ccc_pkg::coord_t'(src_x);
	assign sy  = ccc_pkg::coord_t'(src_y);
	assign dx  = ccc_pkg::coord_t'(dst_x);
	assign dy  = ccc_pkg::coord_t'(dst_y);
	assign sxw = sx + ccc_pkg::coord_t'(w1);
	assign syh = sy + ccc_pkg::coord_t'(h1);
	assign dxw = dx + ccc_pkg::coord_t'(w1);
	assign dyh = dy + ccc_pkg::coord_t'(h1);

	assign cur_left = mon_left_q[cmd.idx];
	assign cur_top  = mon_top_q[cmd.idx];
	assign l = ccc_pkg::coord_t'(cur_left) - ccc_pkg::coord_t'(min_l_q);
	assign t = ccc_pkg::coord_t'(cur_top)  - ccc_pkg::coord_t'(min_t_q);
	assign r = l + ccc_pkg::coord_t'(mon_width_q[cmd.idx]);
	assign b = t + ccc_pkg::coord_t'(mon_height_q[cmd.idx]);

	always_comb begin
		for (int p = 0; p < ccc_pkg::PROBES; p++) begin
			inside_p[p] = (px_q[p] >= l) && (px_q[p] < r) &&
				(py_q[p] >= t) && (py_q[p] < b);
			differs[p] = (found_q[p] != found_q[0]) ||
				(found_q[p] && (hit_q[p] != hit_q[0]));
		end
		stat.flag = |differs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ccc_pkg::MAX_MONITORS; i++) begin
				mon_left_q[i]   <= '0;
				mon_top_q[i]    <= '0;
				mon_width_q[i]  <= '0;
				mon_height_q[i] <= '0;
			end
		end else if (cmd.wr) begin
			mon_left_q[entry_index]   <= entry_left;
			mon_top_q[entry_index]    <= entry_top;
			mon_width_q[entry_index]  <= entry_width;
			mon_height_q[entry_index] <= entry_height;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			min_l_q <= '0;
			min_t_q <= '0;
			px_q[0] <= sx;  py_q[0] <= sy;
			px_q[1] <= sxw; py_q[1] <= sy;
			px_q[2] <= sx;  py_q[2] <= syh;
			px_q[3] <= sxw; py_q[3] <= syh;
			px_q[4] <= dx;  py_q[4] <= dy;
			px_q[5] <= dxw; py_q[5] <= dy;
			px_q[6] <= dx;  py_q[6] <= dyh;
			px_q[7] <= dxw; py_q[7] <= dyh;
		end else if (cmd.min_en) begin
			if (cur_left < min_l_q) begin
				min_l_q <= cur_left;
			end
			if (cur_top < min_t_q) begin
				min_t_q <= cur_top;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < ccc_pkg::PROBES; p++) begin
				found_q[p] <= 1'b0;
			end
		end else if (cmd.start) begin
			for (int p = 0; p < ccc_pkg::PROBES; p++) begin
				found_q[p] <= 1'b0;
			end
		end else if (cmd.probe_en) begin
			for (int p = 0; p < ccc_pkg::PROBES; p++) begin
				if (!found_q[p] && inside_p[p]) begin
					found_q[p] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_en) begin
			for (int p = 0; p < ccc_pkg::PROBES; p++) begin
				if (!found_q[p] && inside_p[p]) begin
					hit_q[p] <= cmd.idx;
				end
			end
		end
	end

endmodule
`default_nettype wire

[tb/tb_cross_monitor_copy_check_unit.sv]
// Self-checking bench for cross_monitor_copy_check_unit: APB writes of monitor_count,
// directed and random table writes and copy queries, with a flag predictor in a scoreboard class.
// Depends on ccc_pkg and the design top level only.
module tb_cross_monitor_copy_check_unit;
	import ccc_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 500;
	localparam logic [2:0] COUNT_ADDR = 3'(4 * int'(REG_MONITOR_COUNT));

	typedef struct {
		opcode_t            op;
		logic [IDX_W-1:0]   idx;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [13:0]        width;
		logic [13:0]        height;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic [13:0]        cw;
		logic [13:0]        ch;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
	} word_t;

	class copy_flag_board;
		logic signed [15:0] tab_left [MAX_MONITORS];
		logic signed [15:0] tab_top [MAX_MONITORS];
		logic [13:0]        tab_width [MAX_MONITORS];
		logic [13:0]        tab_height [MAX_MONITORS];
		logic [CNT_W-1:0]   tab_count;
		bit                 pending_flags [$];
		int                 errors;
		int                 n_words;
		int                 n_queries;
		int                 n_checked;
		int                 n_crossing;

		function new();
			int i;
			for (i = 0; i < MAX_MONITORS; i++) begin
				tab_left[i] = '0;
				tab_top[i] = '0;
				tab_width[i] = '0;
				tab_height[i] = '0;
			end
			tab_count = COUNT_RESET;
			errors = 0;
			n_words = 0;
			n_queries = 0;
			n_checked = 0;
			n_crossing = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] v);
			tab_count = v;
		endfunction

		function int pending();
			return pending_flags.size();
		endfunction

		function int find_hit(longint x, longint y, longint ml, longint mt, int n);
			int i;
			longint l, t, w, h;
			for (i = 0; i < n; i++) begin
				l = longint'(tab_left[i]) - ml;
				t = longint'(tab_top[i]) - mt;
				w = longint'(tab_width[i]);
				h = longint'(tab_height[i]);
				if (x >= l && y >= t && x < l + w && y < t + h)
					return i;
			end
			return -1;
		endfunction

		function bit copy_crosses(word_t it);
			int n, i, home;
			longint sx, sy, dx, dy, cw, ch, w1, h1, ml, mt;
			longint px [8];
			longint py [8];
			n = (int'(tab_count) > MAX_MONITORS) ? MAX_MONITORS : int'(tab_count);
			if (n <= 1)
				return 1'b0;
			sx = longint'(it.sx);
			sy = longint'(it.sy);
			dx = longint'(it.dx);
			dy = longint'(it.dy);
			cw = longint'(it.cw);
			ch = longint'(it.ch);
			w1 = (cw > 0) ? cw - 1 : 0;
			h1 = (ch > 0) ? ch - 1 : 0;
			ml = 0;
			mt = 0;
			for (i = 0; i < n; i++) begin
				if (longint'(tab_left[i]) < ml) ml = longint'(tab_left[i]);
				if (longint'(tab_top[i]) < mt) mt = longint'(tab_top[i]);
			end
			px[0] = sx;      py[0] = sy;
			px[1] = sx + w1; py[1] = sy;
			px[2] = sx;      py[2] = sy + h1;
			px[3] = sx + w1; py[3] = sy + h1;
			px[4] = dx;      py[4] = dy;
			px[5] = dx + w1; py[5] = dy;
			px[6] = dx;      py[6] = dy + h1;
			px[7] = dx + w1; py[7] = dy + h1;
			home = find_hit(sx, sy, ml, mt, n);
			for (i = 0; i < PROBES; i++)
				if (find_hit(px[i], py[i], ml, mt, n) != home)
					return 1'b1;
			return 1'b0;
		endfunction

		function void note_word(word_t it);
			n_words++;
			if (it.op == OP_WRITE) begin
				if (int'(it.idx) < MAX_MONITORS) begin
					tab_left[it.idx] = it.left;
					tab_top[it.idx] = it.top;
					tab_width[it.idx] = it.width;
					tab_height[it.idx] = it.height;
				end
			end else begin
				n_queries++;
				pending_flags.push_back(copy_crosses(it));
			end
		endfunction

		function void check_flag(logic got);
			bit want;
			n_checked++;
			if (got === 1'b1) n_crossing++;
			if (pending_flags.size() == 0) begin
				errors++;
				if (errors < 30) $error("decompose: unexpected result, actual %0d", got);
			end else begin
				want = pending_flags.pop_front();
				if (got !== want) begin
					errors++;
					if (errors < 30)
						$error("decompose mismatch: expected %0d, actual %0d", want, got);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic               opcode;
	logic [IDX_W-1:0]   entry_index;
	logic signed [15:0] entry_left;
	logic signed [15:0] entry_top;
	logic [13:0]        entry_width;
	logic [13:0]        entry_height;
	logic signed [15:0] src_x;
	logic signed [15:0] src_y;
	logic [13:0]        copy_width;
	logic [13:0]        copy_height;
	logic signed [15:0] dst_x;
	logic signed [15:0] dst_y;
	logic               out_valid;
	logic               out_ready;
	logic               decompose;

	copy_flag_board sb;
	int burst_left;
	int cyc;
	int rx_cycle;
	int rx_mode;
	int hold_left;
	bit hold_go;
	bit hold_done;
	int lay_tw, lay_th, lay_cols, lay_ox, lay_oy;

	cross_monitor_copy_check_unit uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .entry_index(entry_index),
		.entry_left(entry_left), .entry_top(entry_top),
		.entry_width(entry_width), .entry_height(entry_height),
		.src_x(src_x), .src_y(src_y), .copy_width(copy_width), .copy_height(copy_height),
		.dst_x(dst_x), .dst_y(dst_y),
		.out_valid(out_valid), .out_ready(out_ready), .decompose(decompose)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic word_t blank_word();
		word_t it;
		it.op = OP_WRITE;
		it.idx = '0;
		it.left = '0;
		it.top = '0;
		it.width = '0;
		it.height = '0;
		it.sx = '0;
		it.sy = '0;
		it.cw = '0;
		it.ch = '0;
		it.dx = '0;
		it.dy = '0;
		return it;
	endfunction

	task automatic send_word(input word_t it);
		int gap;
		gap = 0;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
			burst_left = $urandom_range(1, 48);
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode <= it.op;
		entry_index <= it.idx;
		entry_left <= it.left;
		entry_top <= it.top;
		entry_width <= it.width;
		entry_height <= it.height;
		src_x <= it.sx;
		src_y <= it.sy;
		copy_width <= it.cw;
		copy_height <= it.ch;
		dst_x <= it.dx;
		dst_y <= it.dy;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_word(it);
		burst_left--;
	endtask

	task automatic write_entry(input int idx, input int l, input int t, input int w, input int h);
		word_t it;
		it = blank_word();
		it.op = OP_WRITE;
		it.idx = IDX_W'(idx);
		it.left = 16'(l);
		it.top = 16'(t);
		it.width = 14'(w);
		it.height = 14'(h);
		send_word(it);
	endtask

	task automatic query(input int sx, input int sy, input int cw, input int ch,
			input int dx, input int dy);
		word_t it;
		it = blank_word();
		it.op = OP_QUERY;
		it.sx = 16'(sx);
		it.sy = 16'(sy);
		it.cw = 14'(cw);
		it.ch = 14'(ch);
		it.dx = 16'(dx);
		it.dy = 16'(dy);
		send_word(it);
	endtask

	task automatic reconfigure(input logic [31:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COUNT_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_count(value[CNT_W-1:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		burst_left = 0;
	endtask

	task automatic load_layout();
		int i, bl, bt, w, h;
		lay_tw = $urandom_range(8, 300);
		lay_th = $urandom_range(8, 300);
		case ($urandom_range(0, 2))
			0: lay_cols = 16;
			1: lay_cols = 1;
			default: lay_cols = 4;
		endcase
		bl = $urandom_range(0, 1) ? -int'($urandom_range(0, 3000)) : int'($urandom_range(0, 500));
		bt = $urandom_range(0, 1) ? -int'($urandom_range(0, 3000)) : int'($urandom_range(0, 500));
		lay_ox = (bl < 0) ? 0 : bl;
		lay_oy = (bt < 0) ? 0 : bt;
		for (i = 0; i < MAX_MONITORS; i++) begin
			w = lay_tw;
			h = lay_th;
			case ($urandom_range(0, 15))
				0: w = 0;
				1: h = 0;
				2: w = 2 * lay_tw;
				default: ;
			endcase
			write_entry(i, bl + (i % lay_cols) * lay_tw, bt + (i / lay_cols) * lay_th, w, h);
		end
	endtask

	task automatic layout_query();
		int span_x, span_y, sx, sy, cw, ch, dx, dy;
		span_x = lay_cols * lay_tw;
		span_y = (MAX_MONITORS / lay_cols) * lay_th;
		sx = lay_ox + int'($urandom_range(0, span_x + 20)) - 10;
		sy = lay_oy + int'($urandom_range(0, span_y + 20)) - 10;
		case ($urandom_range(0, 5))
			0: begin cw = 0; ch = $urandom_range(0, lay_th); end
			1: begin cw = $urandom_range(0, 3 * lay_tw); ch = $urandom_range(0, 3 * lay_th); end
			default: begin cw = $urandom_range(1, lay_tw); ch = $urandom_range(1, lay_th); end
		endcase
		if ($urandom_range(0, 1)) begin
			dx = sx + int'($urandom_range(0, 2 * lay_tw)) - lay_tw;
			dy = sy + int'($urandom_range(0, 2 * lay_th)) - lay_th;
		end else begin
			dx = lay_ox + int'($urandom_range(0, span_x + 20)) - 10;
			dy = lay_oy + int'($urandom_range(0, span_y + 20)) - 10;
		end
		query(sx, sy, cw, ch, dx, dy);
	endtask

	task automatic noise_word();
		word_t it;
		it.op = opcode_t'($urandom_range(0, 1));
		it.idx = IDX_W'($urandom);
		it.left = 16'($urandom);
		it.top = 16'($urandom);
		it.width = 14'($urandom);
		it.height = 14'($urandom);
		it.sx = 16'($urandom);
		it.sy = 16'($urandom);
		it.cw = 14'($urandom);
		it.ch = 14'($urandom);
		it.dx = 16'($urandom);
		it.dy = 16'($urandom);
		send_word(it);
	endtask

	task automatic run_phase(input int p);
		int k, r, i;
		case (p % 8)
			0: reconfigure(32'd2);
			1: reconfigure(32'd16);
			2: reconfigure(32'($urandom_range(2, 15)));
			3: reconfigure(32'($urandom_range(0, 1)));
			4: reconfigure(32'($urandom_range(17, 31)));
			5: reconfigure(32'($urandom_range(2, 16)));
			6: reconfigure(32'hA5A5_5A50 | 32'($urandom_range(0, 15)));
			default: reconfigure(32'($urandom_range(3, 8)));
		endcase
		load_layout();
		if (p == 2) hold_go = 1'b1;
		for (k = 0; k < 34; k++) begin
			r = $urandom_range(0, 99);
			if (r < 72) begin
				layout_query();
			end else if (r < 84) begin
				i = $urandom_range(0, MAX_MONITORS - 1);
				write_entry(i, lay_ox + (i % lay_cols) * lay_tw + int'($urandom_range(0, 20)) - 10,
					lay_oy + (i / lay_cols) * lay_th, lay_tw, lay_th);
			end else begin
				noise_word();
			end
		end
	endtask

	// receiver: stall pattern switches among four modes; one long hold-off on request
	initial begin
		out_ready = 1'b0;
		rx_cycle = 0;
		rx_mode = 0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % 50 == 0) rx_mode = $urandom_range(0, 3);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ((rx_cycle % 5) < 3);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_flag(decompose);
		end
	end

	initial begin
		cyc = 0;
		while (cyc < LIMIT_CYCLES) begin
			@(posedge clk);
			cyc++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int p;
		sb = new();
		burst_left = 0;
		hold_go = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		opcode = OP_WRITE;
		entry_index = '0;
		entry_left = '0;
		entry_top = '0;
		entry_width = '0;
		entry_height = '0;
		src_x = '0;
		src_y = '0;
		copy_width = '0;
		copy_height = '0;
		dst_x = '0;
		dst_y = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single monitor after reset, then table extremes and an empty monitor
		query(-32768, -32768, 16383, 16383, 32767, 32767);
		write_entry(0, -32768, -32768, 16383, 16383);
		write_entry(15, 32767, 32767, 16383, 16383);
		write_entry(1, 0, 0, 0, 5);
		reconfigure(32'd0);
		query(0, 0, 100, 100, 20000, 20000);
		reconfigure(32'd2);
		query(0, 0, 0, 0, 0, 0);
		query(16382, 0, 2, 1, 0, 0);
		query(32767, 32767, 16383, 16383, -32768, -32768);
		query(100, 100, 10, 10, 20000, 100);
		query(16382, 16382, 0, 0, 16382, 16382);
		reconfigure(32'd31);
		write_entry(2, -16385, -32768, 100, 100);
		query(16380, 10, 10, 10, 16390, 10);
		query(16383, 0, 16383, 0, 16400, 50);
		query(32767, -32768, 16383, 16383, 32767, -32768);
		reconfigure(32'd16);
		write_entry(3, -16385, -32768, 0, 100);
		query(16390, 10, 5, 5, 16390, 10);
		query(0, 16382, 1, 2, 16383, 0);
		reconfigure(32'd1);
		query(16380, 10, 10, 10, 0, 0);
		reconfigure(32'd17);
		query(16380, 10, 10, 10, 0, 0);

		for (p = 0; p < 20; p++)
			run_phase(p);

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.errors++;
			$error("decompose: %0d expected results never arrived", sb.pending());
		end
		$display("run covered %0d words, %0d copy queries, %0d flags checked (%0d set)",
			sb.n_words, sb.n_queries, sb.n_checked, sb.n_crossing);
		$display("monitor_count swept from 0 to 31 with tiled, empty and overlapping layouts");
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[files.f]
design/ccc_pkg.sv
design/ccc_ctrl.sv
design/ccc_dpath.sv
design/cross_monitor_copy_check_unit.sv
tb/tb_cross_monitor_copy_check_unit.sv
